### hdl/usbe_pkg.sv
// ----------------------------------------------------------------------------
// usbe_pkg
// Types and constants for the u-law encoder with sideband bit embedding.
// ----------------------------------------------------------------------------
package usbe_pkg;

    localparam int QUEUE_BITS_DEF    = 65536;
    localparam int FRAME_SAMPLES_DEF = 160;
    localparam int HEADER_SAMPLES    = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TX_GAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SB_EN   = 1'd1;

    localparam logic [15:0] GAIN_RESET = 16'd4096;
    localparam logic [11:0] SB_MAGIC   = 12'hA5C;
    localparam logic [14:0] ULAW_CLIP  = 15'd32635;
    localparam logic [7:0]  ULAW_BIAS  = 8'h84;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SAMPLE
    } t_state;

    typedef struct packed {
        logic               kind;
        logic [7:0]         data_byte;
        logic [3:0]         bit_count;
        logic signed [15:0] linear_sample;
        logic               link_ready;
    } t_in;

    typedef struct packed {
        logic [7:0] ulaw_byte;
        logic       frame_last;
    } t_out;

endpackage

### hdl/ulaw_sideband_bit_embedder_top.sv
// ----------------------------------------------------------------------------
// ulaw_sideband_bit_embedder_top
// Gain, round and u-law encode of linear samples, with a bit FIFO whose
// contents ride in the low code bits of framed samples.
// ----------------------------------------------------------------------------
// A push item writes its data bits one per cycle into the bit FIFO memory,
// which has a single write port; an item with no bits still takes a step. A
// sample item does frame bookkeeping and reads up to three FIFO bits, one per
// step, on the single read port of the memory, whose read data is registered;
// its last step waits while the multiply stage cannot take a result. The next
// item is taken in the last cycle of the current one. Results then pass a
// multiply stage and an encode/output register. Configuration is written
// through a plain write port, index 0 gain, index 1 sideband enable.
module ulaw_sideband_bit_embedder_top #(
    parameter int QUEUE_BITS    = usbe_pkg::QUEUE_BITS_DEF,
    parameter int FRAME_SAMPLES = usbe_pkg::FRAME_SAMPLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [usbe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [usbe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  usbe_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output usbe_pkg::t_out                     o_out_data
);
    import usbe_pkg::*;

    localparam int AW             = $clog2(QUEUE_BITS);
    localparam int CW             = $clog2(QUEUE_BITS + 1);
    localparam int FRAME_BITS_RAW = (FRAME_SAMPLES - HEADER_SAMPLES) * 3;
    localparam int FRAME_BITS     = (FRAME_BITS_RAW > 511) ? 511 : FRAME_BITS_RAW;
    localparam logic [8:0]    FB9      = 9'(FRAME_BITS);
    localparam logic [CW-1:0] FB_CW    = CW'(FRAME_BITS);
    localparam logic [CW-1:0] Q_FULL   = CW'(QUEUE_BITS);
    localparam logic [AW-1:0] ADDR_END = AW'(QUEUE_BITS - 1);
    localparam logic [7:0]    POS_LAST = 8'(FRAME_SAMPLES - 1);
    localparam logic [7:0]    HDR_POS  = 8'(HEADER_SAMPLES);

    // configuration
    logic [15:0] r_gain;
    logic        r_sb_en;

    // front sequencer
    t_state         r_state, n_state;
    t_in            r_in, n_in;
    logic [2:0]     r_idx, n_idx;
    logic [3:0]     r_n, n_n;
    logic [1:0]     r_ph, n_ph;
    logic [1:0]     r_k, n_k;
    logic [2:0]     r_fs_bits, n_fs_bits;
    logic [2:0]     r_fs_mask, n_fs_mask;
    logic           r_fs_last, n_fs_last;

    // queue and frame state
    logic [AW-1:0]  r_wp, n_wp;
    logic [AW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_queued, n_queued;
    logic [7:0]     r_pos, n_pos;
    logic [23:0]    r_header, n_header;
    logic [8:0]     r_bits_left, n_bits_left;
    logic [2:0]     r_seq, n_seq;
    logic           r_emb, n_emb;

    // bit store
    logic           mem [QUEUE_BITS];
    logic           r_rd;

    // multiply stage
    logic           r_mv;
    logic [31:0]    r_m_prod;
    logic           r_m_neg;
    logic [2:0]     r_m_mask;
    logic [2:0]     r_m_bits;
    logic           r_m_last;

    // output register
    logic           r_ov;
    t_out           r_out;

    logic           m_ready, e_ready;
    logic           accept, item_done, push_done, samp_done;
    logic           wr_en, rd_en, handoff;

    logic           at_start, emb_new, emb_now, hdr_mode;
    logic [8:0]     count;
    logic [23:0]    hdr_new, hdr_now;
    logic [1:0]     k0;
    logic [4:0]     hsh;
    logic [2:0]     hbits, mask0;

    logic [2:0]     hs_bits;
    logic           s_neg;
    logic [16:0]    s_mag;
    logic [31:0]    s_prod;

    logic [19:0]    e_q, e_qr;
    logic [11:0]    e_rem;
    logic           e_up, e_neg;
    logic [14:0]    e_clamp, e_biased;
    logic [2:0]     e_exp;
    logic [3:0]     e_mant;
    logic [7:0]     e_code;
    t_out           e_res;

    assign e_ready = !r_ov || i_out_ready;
    assign m_ready = !r_mv || e_ready;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_sb_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TX_GAIN: r_gain  <= i_cfg_data[15:0];
                CFG_SB_EN:   r_sb_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // frame-start and per-sample decisions, valid in phase 0
    always_comb begin
        at_start = (r_pos == 8'd0);
        emb_new  = r_sb_en && r_in.link_ready;
        count    = (r_queued < FB_CW) ? r_queued[8:0] : FB9;
        hdr_new  = {r_seq, count, SB_MAGIC};
        emb_now  = at_start ? emb_new : r_emb;
        hdr_now  = at_start ? hdr_new : r_header;
        hdr_mode = emb_now && (r_pos < HDR_POS);
        if (emb_now && (r_pos >= HDR_POS)) begin
            k0 = (r_bits_left >= 9'd3) ? 2'd3 : r_bits_left[1:0];
        end else begin
            k0 = 2'd0;
        end
        hsh   = 5'(r_pos[2:0]) * 5'd3;
        hbits = 3'(hdr_now >> hsh);
        if (hdr_mode) begin
            mask0 = 3'b111;
        end else begin
            case (k0)
                2'd3:    mask0 = 3'b111;
                2'd2:    mask0 = 3'b011;
                2'd1:    mask0 = 3'b001;
                default: mask0 = 3'b000;
            endcase
        end
    end

    // FSM next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = i_in_data.kind ? ST_SAMPLE : ST_PUSH;
            end
            ST_PUSH, ST_SAMPLE: begin
                if (accept) begin
                    n_state = i_in_data.kind ? ST_SAMPLE : ST_PUSH;
                end else if (item_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        push_done = (r_n == 4'd0) || ({1'b0, r_idx} == (r_n - 4'd1));
        samp_done = (r_ph != 2'd0) && (r_ph >= r_k) && m_ready;
        item_done = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        handoff   = 1'b0;
        unique case (r_state)
            ST_IDLE: ;
            ST_PUSH: begin
                item_done = push_done;
                wr_en     = (r_n != 4'd0) && (r_queued < Q_FULL);
            end
            ST_SAMPLE: begin
                item_done = samp_done;
                handoff   = samp_done;
                rd_en     = (r_ph == 2'd0) ? (k0 != 2'd0) : (r_ph < r_k);
            end
            default: ;
        endcase
        o_in_ready = (r_state == ST_IDLE) || item_done;
        accept     = i_in_valid && o_in_ready;
    end

    // sequencer datapath next values
    always_comb begin
        n_in        = r_in;
        n_idx       = r_idx;
        n_n         = r_n;
        n_ph        = r_ph;
        n_k         = r_k;
        n_fs_bits   = r_fs_bits;
        n_fs_mask   = r_fs_mask;
        n_fs_last   = r_fs_last;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_queued    = r_queued;
        n_pos       = r_pos;
        n_header    = r_header;
        n_bits_left = r_bits_left;
        n_seq       = r_seq;
        n_emb       = r_emb;

        if (r_state == ST_PUSH) begin
            n_idx = r_idx + 3'd1;
            if (wr_en) begin
                n_wp     = (r_wp == ADDR_END) ? '0 : r_wp + AW'(1);
                n_queued = r_queued + CW'(1);
            end
        end

        if (r_state == ST_SAMPLE) begin
            if (r_ph == 2'd0) begin
                if (at_start) begin
                    n_emb = emb_new;
                    if (emb_new) begin
                        n_header    = hdr_new;
                        n_bits_left = count;
                        n_seq       = r_seq + 3'd1;
                    end else begin
                        n_bits_left = 9'd0;
                    end
                end
                n_pos     = (r_pos == POS_LAST) ? 8'd0 : r_pos + 8'd1;
                n_k       = k0;
                n_fs_bits = hdr_mode ? hbits : 3'b000;
                n_fs_mask = mask0;
                n_fs_last = (r_pos == POS_LAST);
            end else if (r_ph < r_k) begin
                n_fs_bits[2'(r_ph - 2'd1)] = r_rd;
            end
            if (rd_en) begin
                n_rp        = (r_rp == ADDR_END) ? '0 : r_rp + AW'(1);
                n_queued    = r_queued - CW'(1);
                n_bits_left = n_bits_left - 9'd1;
            end
            if (!((r_ph != 2'd0) && (r_ph >= r_k))) n_ph = r_ph + 2'd1;
        end

        if (accept) begin
            n_in  = i_in_data;
            n_idx = 3'd0;
            n_ph  = 2'd0;
            n_n   = (i_in_data.bit_count > 4'd8) ? 4'd8 : i_in_data.bit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ph        <= 2'd0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_queued    <= '0;
            r_pos       <= 8'd0;
            r_header    <= 24'd0;
            r_bits_left <= 9'd0;
            r_seq       <= 3'd0;
            r_emb       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ph        <= n_ph;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_queued    <= n_queued;
            r_pos       <= n_pos;
            r_header    <= n_header;
            r_bits_left <= n_bits_left;
            r_seq       <= n_seq;
            r_emb       <= n_emb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_idx     <= n_idx;
        r_n       <= n_n;
        r_k       <= n_k;
        r_fs_bits <= n_fs_bits;
        r_fs_mask <= n_fs_mask;
        r_fs_last <= n_fs_last;
    end

    // bit store, one write and one read port
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_wp] <= r_in.data_byte[r_idx];
        if (rd_en) r_rd <= mem[r_rp];
    end

    // hand-off into the multiply stage
    always_comb begin
        hs_bits = r_fs_bits;
        if (r_k != 2'd0) hs_bits[2'(r_k - 2'd1)] = r_rd;
        s_neg  = r_in.linear_sample[15];
        s_mag  = s_neg ? (17'h10000 - {1'b0, r_in.linear_sample})
                       : {1'b0, r_in.linear_sample};
        s_prod = {15'd0, s_mag} * {16'd0, r_gain};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (handoff) begin
            r_mv <= 1'b1;
        end else if (e_ready) begin
            r_mv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (handoff) begin
            r_m_prod <= s_prod;
            r_m_neg  <= s_neg;
            r_m_mask <= r_fs_mask;
            r_m_bits <= hs_bits;
            r_m_last <= r_fs_last;
        end
    end

    // round, clamp, u-law encode, insert sideband bits
    always_comb begin
        e_q      = r_m_prod[31:12];
        e_rem    = r_m_prod[11:0];
        e_up     = (e_rem > 12'h800) || ((e_rem == 12'h800) && e_q[0]);
        e_qr     = e_q + 20'(e_up);
        e_neg    = r_m_neg && (e_qr != 20'd0);
        e_clamp  = (e_qr > 20'(ULAW_CLIP)) ? ULAW_CLIP : e_qr[14:0];
        e_biased = e_clamp + 15'(ULAW_BIAS);
        e_exp    = 3'd0;
        for (int b = 1; b < 8; b++) begin
            if (e_biased[7 + b]) e_exp = 3'(b);
        end
        e_mant = 4'(e_biased >> (4'(e_exp) + 4'd3));
        e_code = ~{e_neg, e_exp, e_mant};
        e_res.ulaw_byte  = {e_code[7:3], (e_code[2:0] & ~r_m_mask) | (r_m_bits & r_m_mask)};
        e_res.frame_last = r_m_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_mv && e_ready) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mv && e_ready) r_out <= e_res;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

### hdl/usbe_checker.sv
// ----------------------------------------------------------------------------
// usbe_checker
// Port-level checks for the u-law sideband embedder, bound to the top level.
// ----------------------------------------------------------------------------
module usbe_checker #(
    parameter int FRAME_SAMPLES = usbe_pkg::FRAME_SAMPLES_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input usbe_pkg::t_in                   i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input usbe_pkg::t_out                  o_out_data
);
    import usbe_pkg::*;

    localparam logic [7:0] POS_LAST = 8'(FRAME_SAMPLES - 1);

    logic       in_xfer, out_xfer, samp_xfer;
    logic [7:0] r_out_pos;
    logic [2:0] r_pending;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign samp_xfer = in_xfer && i_in_data.kind;
    assign out_xfer  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_pos <= 8'd0;
            r_pending <= 3'd0;
        end else begin
            if (out_xfer) r_out_pos <= (r_out_pos == POS_LAST) ? 8'd0 : r_out_pos + 8'd1;
            r_pending <= r_pending + 3'(samp_xfer) - 3'(out_xfer);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (o_out_data.frame_last == (r_out_pos == POS_LAST)))
        else $error("frame_last out of step with frame count");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (r_pending != 3'd0) || samp_xfer)
        else $error("result without a sample");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd3)
        else $error("too many samples in flight");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind ulaw_sideband_bit_embedder_top usbe_checker #(
    .FRAME_SAMPLES(FRAME_SAMPLES)
) u_usbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the u-law encoder with sideband bit embedding.
// Drives push and sample transfers with random gaps and back-pressure, keeps
// its own bit-accurate predictor of gain, rounding, u-law encoding, framing
// and the bit FIFO, and compares every output transfer in order.
// ----------------------------------------------------------------------------
module testbench;
    import usbe_pkg::*;

    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;
    localparam int   FRAME_BITS_RAW = (FRAME_SAMPLES_DEF - HEADER_SAMPLES) * 3;
    localparam int   FRAME_BITS  = (FRAME_BITS_RAW > 511) ? 511 : FRAME_BITS_RAW;
    localparam int   CYCLE_LIMIT = 3_000_000;
    localparam int   HOLD_AT     = 300;
    localparam int   HOLD_CYCLES = 600;
    localparam int   SETTLE_CYCLES = 16;

    class ulaw_sideband_predictor;
        bit          fifo_bits[$];
        int unsigned frame_pos;
        logic [23:0] header;
        int unsigned bits_left;
        logic [2:0]  seq;
        bit          embedding;
        logic [15:0] gain;
        bit          sb_en;
        t_out        expected_codes[$];
        int unsigned errors;

        function void reset();
            fifo_bits.delete();
            expected_codes.delete();
            frame_pos = 0;
            header    = '0;
            bits_left = 0;
            seq       = '0;
            embedding = 1'b0;
            gain      = GAIN_RESET;
            sb_en     = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_TX_GAIN) begin
                gain = val;
            end else if (idx == CFG_SB_EN) begin
                sb_en = val[0];
            end
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction

        function logic [7:0] ulaw_code(bit neg, logic [63:0] mag_in);
            logic [15:0] mag;
            logic [15:0] mask;
            logic [15:0] mant;
            int unsigned ex;
            logic [7:0]  code;
            if (mag_in > ULAW_CLIP) mag_in = ULAW_CLIP;
            mag  = mag_in[15:0] + ULAW_BIAS;
            ex   = 7;
            mask = 16'h4000;
            while (ex > 0 && (mag & mask) == 0) begin
                ex--;
                mask >>= 1;
            end
            mant = (mag >> (ex + 3)) & 16'h000F;
            code = {neg, 3'(ex), mant[3:0]};
            return ~code;
        endfunction

        function logic [7:0] scale_encode(logic [15:0] raw);
            bit          neg;
            logic [16:0] m;
            logic [63:0] prod;
            logic [63:0] q;
            logic [11:0] rem;
            neg  = raw[15];
            m    = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
            prod = 64'(m) * 64'(gain);
            q    = prod >> 12;
            rem  = prod[11:0];
            if (rem > 12'h800 || (rem == 12'h800 && q[0])) q++;
            return ulaw_code(neg && q != 0, q);
        endfunction

        function void absorb_item(t_in it);
            int unsigned n;
            int unsigned pos;
            int unsigned count;
            logic [7:0]  code;
            t_out        res;
            if (it.kind == KIND_PUSH) begin
                n = (it.bit_count > 8) ? 8 : it.bit_count;
                for (int i = 0; i < n; i++) begin
                    if (fifo_bits.size() < QUEUE_BITS_DEF) fifo_bits.push_back(it.data_byte[i]);
                end
                return;
            end
            if (frame_pos >= FRAME_SAMPLES_DEF) frame_pos = 0;
            pos = frame_pos;
            if (pos == 0) begin
                embedding = sb_en && it.link_ready;
                if (embedding) begin
                    count = (fifo_bits.size() < FRAME_BITS) ? fifo_bits.size() : FRAME_BITS;
                    header    = {seq, 9'(count), SB_MAGIC};
                    bits_left = count;
                    seq++;
                end else begin
                    bits_left = 0;
                end
            end
            code = scale_encode(it.linear_sample);
            if (embedding) begin
                if (pos < HEADER_SAMPLES) begin
                    code[2:0] = 3'(header >> (3 * pos));
                end else begin
                    for (int sh = 0; sh < 3 && bits_left > 0; sh++) begin
                        code[sh] = (fifo_bits.size() > 0) ? fifo_bits.pop_front() : 1'b0;
                        bits_left--;
                    end
                end
            end
            res.ulaw_byte  = code;
            res.frame_last = (pos == FRAME_SAMPLES_DEF - 1);
            expected_codes.push_back(res);
            frame_pos = pos + 1;
            if (frame_pos >= FRAME_SAMPLES_DEF) frame_pos = 0;
        endfunction

        function void check_code(t_out got);
            t_out want;
            if (expected_codes.size() == 0) begin
                $error("unexpected transfer: ulaw_byte %0h frame_last %0b",
                       got.ulaw_byte, got.frame_last);
                errors++;
                return;
            end
            want = expected_codes.pop_front();
            if (got.ulaw_byte !== want.ulaw_byte) begin
                $error("ulaw_byte expected %0h actual %0h", want.ulaw_byte, got.ulaw_byte);
                errors++;
            end
            if (got.frame_last !== want.frame_last) begin
                $error("frame_last expected %0b actual %0b", want.frame_last, got.frame_last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out                  out_data;

    ulaw_sideband_predictor sb;
    bit send_idle;
    bit sink_idle;
    int cycle_count = 0;

    ulaw_sideband_bit_embedder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) sb.check_code(out_data);
    end

    function automatic t_in push_item(logic [7:0] data, logic [3:0] cnt);
        t_in it;
        it               = '0;
        it.kind          = KIND_PUSH;
        it.data_byte     = data;
        it.bit_count     = cnt;
        it.linear_sample = 16'($urandom);
        it.link_ready    = 1'($urandom);
        return it;
    endfunction

    function automatic t_in sample_item(logic [15:0] s, logic link);
        t_in it;
        it               = '0;
        it.kind          = KIND_SAMPLE;
        it.data_byte     = 8'($urandom);
        it.bit_count     = 4'($urandom);
        it.linear_sample = s;
        it.link_ready    = link;
        return it;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            1:       return 16'($urandom_range(0, 600) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(t_in it);
        int gap;
        gap = send_idle ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        sb.absorb_item(it);
    endtask

    task automatic finish_phase();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic run_mixed(int n, int push_pct);
        logic [3:0] cnt;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < push_pct) begin
                cnt = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
                send_item(push_item(8'($urandom), cnt));
            end else begin
                send_item(sample_item(rand_sample(), $urandom_range(0, 99) < 85));
            end
        end
    endtask

    initial begin
        int gap;
        int xfers;
        xfers = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (xfers == HOLD_AT) gap = HOLD_CYCLES;
            else gap = sink_idle ? $urandom_range(0, 19) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            xfers++;
        end
    end

    initial begin
        logic [15:0] g;
        sb = new;
        sb.reset();
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_data  <= '0;
        send_idle = 1'b1;
        sink_idle = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // directed: push counts, extremes, rounding, clamp
        write_reg(CFG_TX_GAIN, GAIN_RESET);
        write_reg(CFG_SB_EN, 16'd1);
        send_item(push_item(8'hA5, 4'd8));
        send_item(push_item(8'hFF, 4'd15));
        send_item(push_item(8'h3C, 4'd0));
        send_item(push_item(8'h06, 4'd3));
        send_item(push_item(8'h5A, 4'd9));
        send_item(sample_item(16'h7FFF, 1'b1));
        send_item(sample_item(16'h8000, 1'b0));
        send_item(sample_item(16'h0000, 1'b1));
        send_item(sample_item(16'hFFFF, 1'b1));
        send_item(sample_item(16'h0001, 1'b1));
        send_item(sample_item(16'hFF7F, 1'b1));
        finish_phase();
        write_reg(CFG_TX_GAIN, 16'h0800);
        send_item(sample_item(16'h0001, 1'b1));
        send_item(sample_item(16'h0003, 1'b1));
        send_item(sample_item(16'hFFFF, 1'b1));
        send_item(sample_item(16'hFFFD, 1'b1));
        send_item(sample_item(16'h0005, 1'b1));
        finish_phase();
        write_reg(CFG_TX_GAIN, 16'hFFFF);
        send_item(sample_item(16'h8000, 1'b1));
        send_item(sample_item(16'h7FFF, 1'b1));
        send_item(sample_item(16'd12345, 1'b1));
        finish_phase();
        write_reg(CFG_TX_GAIN, 16'h0000);
        send_item(sample_item(16'h8000, 1'b1));
        send_item(sample_item(16'd100, 1'b1));
        finish_phase();

        // random phases over several gain and enable settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       g = 16'hFFFF;
                1:       g = 16'h0000;
                2:       g = GAIN_RESET;
                3:       g = 16'($urandom_range(0, 8192));
                default: g = 16'($urandom);
            endcase
            write_reg(CFG_TX_GAIN, g);
            write_reg(CFG_SB_EN, (ph == 1) ? 16'd0 : 16'($urandom_range(0, 99) < 85));
            send_idle = (ph == 0) ? 1'b1 : 1'($urandom);
            sink_idle = (ph == 0) ? 1'b1 : 1'($urandom);
            run_mixed(180, 25 + 5 * ph);
            finish_phase();
        end

        // build a deep bit backlog with the sideband off, then drain it
        write_reg(CFG_SB_EN, 16'd0);
        write_reg(CFG_TX_GAIN, 16'($urandom));
        send_idle = 1'b0;
        sink_idle = 1'($urandom);
        for (int i = 0; i < 150; i++) begin
            send_item(push_item(8'($urandom), 4'($urandom_range(8, 15))));
            if (i % 64 == 63) send_item(sample_item(rand_sample(), 1'($urandom)));
        end
        finish_phase();
        write_reg(CFG_SB_EN, 16'd1);
        send_idle = 1'b1;
        sink_idle = 1'b1;
        run_mixed(250, 30);
        finish_phase();

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/usbe_pkg.sv
hdl/ulaw_sideband_bit_embedder_top.sv
hdl/usbe_checker.sv
tb/sv/testbench.sv
